// File: rtl/assert_macros.svh
// Assertion helpers, included by rtl/adabelief_update.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ABEL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ABEL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// File: rtl/abel_pkg.sv
`default_nettype none
package abel_pkg;

   typedef enum logic {
      MODE_DIV  = 1'b0,
      MODE_SQRT = 1'b1
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;

   localparam logic [2:0] CSR_WEIGHT_COUNT  = 3'd0;
   localparam logic [2:0] CSR_DECAY_FIRST   = 3'd1;
   localparam logic [2:0] CSR_DECAY_SECOND  = 3'd2;
   localparam logic [2:0] CSR_LEARN_RATE    = 3'd3;
   localparam logic [2:0] CSR_EPSILON_OUTER = 3'd4;
   localparam logic [2:0] CSR_EPSILON_INNER = 3'd5;

   localparam logic [7:0]  RST_WEIGHT_COUNT  = 8'd97;
   localparam logic [15:0] RST_DECAY_FIRST   = 16'd58982;
   localparam logic [15:0] RST_DECAY_SECOND  = 16'd64881;
   localparam logic [23:0] RST_LEARN_RATE    = 24'd503316;
   localparam logic [15:0] RST_EPSILON_OUTER = 16'd1;
   localparam logic [15:0] RST_EPSILON_INNER = 16'd1;

endpackage
`default_nettype wire

// File: rtl/adabelief_update.sv
`default_nettype none
// AdaBelief weight update, one weight per transaction.
// The req_ channel carries a weight index, its value, its gradient and a flag
// marking the last weight of an optimizer step. For every request transaction
// exactly one rsp_ transaction follows with the index, the updated value and an
// index error flag. Registers are written through the csr_ channel, which is
// always ready; a write to either decay rate also reloads its decay power.
// A valid item passes through three 64-step divisions and a 32-step square
// root on the shared iterative unit, plus ten multiply and accumulate steps
// and a final load of the output register. Ending a step adds the decay
// power updates in states PW1 to PW3. An item whose index is out of range
// skips the computation and goes straight to the output register, or first
// to the decay power updates when it ends a step. The block works on one
// item at a time and accepts the next once the previous result sits in the
// output register. A stalled receiver holds the result in that register;
// the next item still computes, and then waits for the register to drain.
// After reset, both moment memories are cleared one entry per cycle, and no
// request is accepted until the sweep ends.
module adabelief_update #(
   parameter int MAX_WEIGHTS = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [6:0]         req_weight_index,
   input  wire logic signed [31:0] req_weight_value,
   input  wire logic signed [31:0] req_gradient,
   input  wire logic               req_last_of_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [6:0]              rsp_echo_index,
   output logic signed [31:0]      rsp_new_value,
   output logic                    rsp_index_error,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

`include "assert_macros.svh"

   localparam int AW = $clog2(MAX_WEIGHTS);

   // One-hot sequencer states.
   typedef enum logic [19:0] {
      ST_CLEAR = 20'h00001,
      ST_IDLE  = 20'h00002,
      ST_RD    = 20'h00004,
      ST_M1    = 20'h00008,
      ST_M2    = 20'h00010,
      ST_D1    = 20'h00020,
      ST_D2    = 20'h00040,
      ST_D3    = 20'h00080,
      ST_D4    = 20'h00100,
      ST_DV1   = 20'h00200,
      ST_DV2   = 20'h00400,
      ST_SQ    = 20'h00800,
      ST_PL    = 20'h01000,
      ST_PH    = 20'h02000,
      ST_PS    = 20'h04000,
      ST_DV3   = 20'h08000,
      ST_PW1   = 20'h10000,
      ST_PW2   = 20'h20000,
      ST_PW3   = 20'h40000,
      ST_FIN   = 20'h80000
   } state_type;

   state_type state_ff;

   // Configuration and step state.
   logic [7:0]  wcount_ff;
   logic [15:0] b1_ff;
   logic [15:0] b2_ff;
   logic [23:0] lr_ff;
   logic [15:0] eps_o_ff;
   logic [15:0] eps_i_ff;
   logic [15:0] p1_ff;
   logic [15:0] p2_ff;
   logic [31:0] step_ff;
   logic [AW-1:0] clr_ff;

   // Item and working registers.
   logic [6:0]         idx_ff;
   logic [AW-1:0]      addr_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] g_ff;
   logic               last_ff;
   logic               err_ff;
   logic signed [31:0] m_ff;
   logic [31:0]        s_ff;
   logic [31:0]        d2_ff;
   logic [39:0]        mh_ff;
   logic [33:0]        den_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] prod_ff;
   logic signed [31:0] res_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [6:0]         rsp_idx_ff;
   logic signed [31:0] rsp_val_ff;
   logic               rsp_err_ff;

   // Store ports.
   logic               st_wr_en;
   logic [AW-1:0]      st_wr_addr;
   logic signed [31:0] st_wr_m;
   logic [31:0]        st_wr_s;
   logic signed [31:0] st_rd_m;
   logic [31:0]        st_rd_s;

   // Shared iterative unit.
   abel_pkg::iter_cmd_type iter_cmd;
   abel_pkg::iter_sts_type iter_sts;
   logic [63:0]            iter_a;
   logic [33:0]            iter_b;
   logic [63:0]            iter_res;

   // Multiplier.
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_in;

   // Datapath helpers.
   logic               accept;
   logic               req_err;
   logic [31:0]        idx_wide;
   logic [16:0]        omb1;
   logic [16:0]        omb2;
   logic [16:0]        dv1;
   logic [16:0]        dv2;
   logic signed [65:0] m_sum;
   logic signed [65:0] s_sum;
   logic signed [65:0] d2_sum;
   logic [31:0]        d2_calc;
   logic signed [32:0] dtmp;
   logic signed [32:0] dabs;
   logic [31:0]        dmag;
   logic signed [32:0] mneg;
   logic [31:0]        mmag;
   logic [63:0]        div1_a;
   logic [63:0]        div2_a;
   logic [39:0]        mh_in;
   logic [63:0]        inner_sum;
   logic [39:0]        inner;
   logic [33:0]        den_sum;
   logic [33:0]        den_in;
   logic [63:0]        full_prod;
   logic [63:0]        div3_a;
   logic [33:0]        qs;
   logic signed [35:0] res_sum;
   logic signed [31:0] res_in;
   logic               out_free;
   logic               iter_wait;
   logic               wr_legal;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign idx_wide = {25'd0, req_weight_index};
   assign req_err  = ({1'b0, req_weight_index} >= wcount_ff) ||
                     (idx_wide >= 32'(MAX_WEIGHTS));

   assign omb1 = 17'd65536 - {1'b0, b1_ff};
   assign omb2 = 17'd65536 - {1'b0, b2_ff};
   assign dv1  = 17'd65536 - {1'b0, p1_ff};
   assign dv2  = 17'd65536 - {1'b0, p2_ff};

   // Moment updates, rounded half up after the 2^16 scale; the squared difference after a 2^24 scale.
   assign m_sum   = acc_ff + prod_ff + 66'sd32768;
   assign s_sum   = acc_ff + prod_ff + 66'sd32768;
   assign d2_sum  = prod_ff + 66'sd8388608;
   assign d2_calc = (d2_sum[65:56] != 10'd0) ? 32'hFFFF_FFFF : d2_sum[55:24];

   always_comb begin
      dtmp = {g_ff[31], g_ff} - {m_ff[31], m_ff};
      dabs = dtmp[32] ? -dtmp : dtmp;
      dmag = dabs[32] ? 32'hFFFF_FFFF : dabs[31:0];
      mneg = -$signed({m_ff[31], m_ff});
      mmag = m_ff[31] ? mneg[31:0] : m_ff;
   end

   // Bias correction dividends, each with half the divisor for rounding.
   assign div1_a = {16'd0, mmag, 16'd0} + {48'd0, dv1[16:1]};
   assign div2_a = {16'd0, s_ff, 16'd0} + {48'd0, dv2[16:1]};
   assign mh_in  = (iter_res[63:40] != 24'd0) ? 40'hFF_FFFF_FFFF : iter_res[39:0];

   assign inner_sum = iter_res + {48'd0, eps_i_ff};
   assign inner     = (inner_sum[63:40] != 24'd0) ? 40'hFF_FFFF_FFFF : inner_sum[39:0];

   // A zero denominator is forced to one LSB.
   assign den_sum = {2'b00, iter_res[31:0]} + {18'd0, eps_o_ff};
   assign den_in  = (den_sum == 34'd0) ? 34'd1 : den_sum;

   // The low partial product sits in the accumulator and the high one in the
   // product register when the final division starts.
   assign full_prod = acc_ff[63:0] + {prod_ff[31:0], 32'd0};
   assign div3_a    = full_prod + {31'd0, den_ff[33:1]};

   always_comb begin
      qs = (iter_res > 64'h2_0000_0000) ? 34'h2_0000_0000 : iter_res[33:0];
      if (m_ff[31]) begin
         res_sum = {{4{x_ff[31]}}, x_ff} + $signed({2'b00, qs});
      end else begin
         res_sum = {{4{x_ff[31]}}, x_ff} - $signed({2'b00, qs});
      end
      if (!res_sum[35] && (res_sum[34:31] != 4'h0)) begin
         res_in = 32'sh7FFF_FFFF;
      end else if (res_sum[35] && (res_sum[34:31] != 4'hF)) begin
         res_in = 32'sh8000_0000;
      end else begin
         res_in = res_sum[31:0];
      end
   end

   // Operand selection for the single shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RD: begin
            mul_a = {17'd0, b1_ff};
            mul_b = {st_rd_m[31], st_rd_m};
         end
         ST_M1: begin
            mul_a = {16'd0, omb1};
            mul_b = {g_ff[31], g_ff};
         end
         ST_D1: begin
            mul_a = {1'b0, dmag};
            mul_b = {1'b0, dmag};
         end
         ST_D2: begin
            mul_a = {17'd0, b2_ff};
            mul_b = {1'b0, st_rd_s};
         end
         ST_D3: begin
            mul_a = {16'd0, omb2};
            mul_b = {1'b0, d2_ff};
         end
         ST_PL: begin
            mul_a = {9'd0, lr_ff};
            mul_b = {1'b0, mh_ff[31:0]};
         end
         ST_PH: begin
            mul_a = {9'd0, lr_ff};
            mul_b = {25'd0, mh_ff[39:32]};
         end
         ST_PW1: begin
            mul_a = {17'd0, p1_ff};
            mul_b = {17'd0, b1_ff};
         end
         ST_PW2: begin
            mul_a = {17'd0, p2_ff};
            mul_b = {17'd0, b2_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // Commands to the shared divide and root unit.
   always_comb begin
      iter_cmd.start = 1'b0;
      iter_cmd.mode  = abel_pkg::MODE_DIV;
      iter_a         = '0;
      iter_b         = '0;
      case (state_ff)
         ST_D4: begin
            iter_cmd.start = 1'b1;
            iter_a         = div1_a;
            iter_b         = {17'd0, dv1};
         end
         ST_DV1: begin
            iter_cmd.start = iter_sts.done;
            iter_a         = div2_a;
            iter_b         = {17'd0, dv2};
         end
         ST_DV2: begin
            iter_cmd.start = iter_sts.done;
            iter_cmd.mode  = abel_pkg::MODE_SQRT;
            iter_a         = {inner, 24'd0};
         end
         ST_PS: begin
            iter_cmd.start = 1'b1;
            iter_a         = div3_a;
            iter_b         = den_ff;
         end
         default: begin
            iter_cmd.start = 1'b0;
         end
      endcase
   end

   // Memory writes: the clearing sweep after reset, then one write per in-range item.
   assign st_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_D4);
   assign st_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign st_wr_m    = (state_ff == ST_CLEAR) ? 32'sd0 : m_ff;
   assign st_wr_s    = (state_ff == ST_CLEAR) ? 32'd0 : s_sum[47:16];

   abel_store #(
      .DEPTH (MAX_WEIGHTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (idx_wide[AW-1:0]),
      .rd_m    (st_rd_m),
      .rd_s    (st_rd_s),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_m    (st_wr_m),
      .wr_s    (st_wr_s)
   );

   abel_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (iter_cmd),
      .op_a   (iter_a),
      .op_b   (iter_b),
      .sts    (iter_sts),
      .result (iter_res)
   );

   // Sequencer, configuration and step state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wcount_ff    <= abel_pkg::RST_WEIGHT_COUNT;
         b1_ff        <= abel_pkg::RST_DECAY_FIRST;
         b2_ff        <= abel_pkg::RST_DECAY_SECOND;
         lr_ff        <= abel_pkg::RST_LEARN_RATE;
         eps_o_ff     <= abel_pkg::RST_EPSILON_OUTER;
         eps_i_ff     <= abel_pkg::RST_EPSILON_INNER;
         p1_ff        <= abel_pkg::RST_DECAY_FIRST;
         p2_ff        <= abel_pkg::RST_DECAY_SECOND;
         step_ff      <= '0;
      end else begin
         // A new result may be loaded in the same cycle the old one drains.
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(MAX_WEIGHTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (!req_err) begin
                     state_ff <= ST_RD;
                  end else if (req_last_of_step) begin
                     state_ff <= ST_PW1;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_RD:  state_ff <= ST_M1;
            ST_M1:  state_ff <= ST_M2;
            ST_M2:  state_ff <= ST_D1;
            ST_D1:  state_ff <= ST_D2;
            ST_D2:  state_ff <= ST_D3;
            ST_D3:  state_ff <= ST_D4;
            ST_D4:  state_ff <= ST_DV1;
            ST_DV1: begin
               if (iter_sts.done) begin
                  state_ff <= ST_DV2;
               end
            end
            ST_DV2: begin
               if (iter_sts.done) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (iter_sts.done) begin
                  state_ff <= ST_PL;
               end
            end
            ST_PL:  state_ff <= ST_PH;
            ST_PH:  state_ff <= ST_PS;
            ST_PS:  state_ff <= ST_DV3;
            ST_DV3: begin
               if (iter_sts.done) begin
                  state_ff <= last_ff ? ST_PW1 : ST_FIN;
               end
            end
            ST_PW1: state_ff <= ST_PW2;
            ST_PW2: begin
               p1_ff    <= prod_ff[31:16];
               state_ff <= ST_PW3;
            end
            ST_PW3: begin
               p2_ff    <= prod_ff[31:16];
               step_ff  <= step_ff + 32'd1;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // The user must write registers only while the sequencer is idle; the block does not enforce it.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               abel_pkg::CSR_WEIGHT_COUNT:  wcount_ff <= csr_data[7:0];
               abel_pkg::CSR_DECAY_FIRST: begin
                  b1_ff <= csr_data[15:0];
                  p1_ff <= csr_data[15:0];
               end
               abel_pkg::CSR_DECAY_SECOND: begin
                  b2_ff <= csr_data[15:0];
                  p2_ff <= csr_data[15:0];
               end
               abel_pkg::CSR_LEARN_RATE:    lr_ff    <= csr_data[23:0];
               abel_pkg::CSR_EPSILON_OUTER: eps_o_ff <= csr_data[15:0];
               abel_pkg::CSR_EPSILON_INNER: eps_i_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         idx_ff  <= req_weight_index;
         addr_ff <= idx_wide[AW-1:0];
         x_ff    <= req_weight_value;
         g_ff    <= req_gradient;
         last_ff <= req_last_of_step;
         err_ff  <= req_err;
         res_ff  <= req_weight_value;
      end
      case (state_ff)
         ST_M1:  acc_ff <= prod_ff;
         ST_M2:  m_ff   <= m_sum[47:16];
         ST_D2:  d2_ff  <= d2_calc;
         ST_D3:  acc_ff <= prod_ff;
         ST_D4:  s_ff   <= s_sum[47:16];
         ST_DV1: begin
            if (iter_sts.done) begin
               mh_ff <= mh_in;
            end
         end
         ST_SQ: begin
            if (iter_sts.done) begin
               den_ff <= den_in;
            end
         end
         ST_PH:  acc_ff <= prod_ff;
         ST_DV3: begin
            if (iter_sts.done) begin
               res_ff <= res_in;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_idx_ff <= idx_ff;
               rsp_val_ff <= res_ff;
               rsp_err_ff <= err_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_index  = rsp_idx_ff;
   assign rsp_new_value   = rsp_val_ff;
   assign rsp_index_error = rsp_err_ff;

   // States that wait on the shared unit, and the states allowed to write.
   assign iter_wait = (state_ff == ST_DV1) || (state_ff == ST_DV2) ||
                      (state_ff == ST_SQ) || (state_ff == ST_DV3);
   assign wr_legal  = (state_ff == ST_CLEAR) || ((state_ff == ST_D4) && !err_ff);

   // The shared unit only finishes while the sequencer waits for it.
   `ABEL_ASSERT(a_iter_done_wait, clock, reset, iter_sts.done |-> iter_wait, "iterative unit finished outside a wait state")
   // Memories are written only by the clearing sweep or a valid item.
   `ABEL_ASSERT(a_store_write, clock, reset, st_wr_en |-> wr_legal, "moment store written outside its update step")
   // The step count advances by one at the end of a step.
   `ABEL_ASSERT_NEXT(a_step_adv, clock, reset, state_ff == ST_PW3, step_ff == $past(step_ff) + 32'd1, "step count did not advance")

endmodule
`default_nettype wire

// File: rtl/abel_iter.sv
`default_nettype none
// Restoring divider and square root sharing one compare and subtract path.
module abel_iter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abel_pkg::iter_cmd_type cmd,
   input  wire logic [63:0]           op_a,
   input  wire logic [33:0]           op_b,
   output abel_pkg::iter_sts_type     sts,
   output logic [63:0]                result
);

   abel_pkg::iter_mode_type mode_ff;
   logic [63:0] x_ff;
   logic [35:0] r_ff;
   logic [31:0] root_ff;
   logic [33:0] b_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [35:0] a_op;
   logic [35:0] b_op;
   logic [36:0] diff;
   logic        take;
   logic [35:0] r_in;

   always_comb begin
      if (mode_ff == abel_pkg::MODE_SQRT) begin
         a_op = {r_ff[33:0], x_ff[63:62]};
         b_op = {2'b00, root_ff, 2'b01};
      end else begin
         a_op = {r_ff[34:0], x_ff[63]};
         b_op = {2'b00, b_ff};
      end
      diff = {1'b0, a_op} - {1'b0, b_op};
      take = !diff[36];
      r_in = take ? diff[35:0] : a_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            mode_ff <= cmd.mode;
            x_ff    <= op_a;
            b_ff    <= op_b;
            r_ff    <= '0;
            root_ff <= '0;
            cnt_ff  <= (cmd.mode == abel_pkg::MODE_SQRT) ?
                       6'(abel_pkg::SQRT_STEPS - 1) : 6'(abel_pkg::DIV_STEPS - 1);
         end else if (busy_ff) begin
            r_ff <= r_in;
            if (mode_ff == abel_pkg::MODE_SQRT) begin
               x_ff    <= {x_ff[61:0], 2'b00};
               root_ff <= {root_ff[30:0], take};
            end else begin
               x_ff <= {x_ff[62:0], take};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (mode_ff == abel_pkg::MODE_SQRT) ? {32'd0, root_ff} : x_ff;

endmodule
`default_nettype wire

// File: rtl/abel_store.sv
`default_nettype none
// First-moment and belief memories, one write and one registered read port.
module abel_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic signed [31:0]      rd_m,
   output logic [31:0]             rd_s,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic signed [31:0] wr_m,
   input  wire logic [31:0]        wr_s
);

   logic signed [31:0] m_mem [DEPTH];
   logic [31:0]        s_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         m_mem[wr_addr] <= wr_m;
         s_mem[wr_addr] <= wr_s;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_m <= m_mem[rd_addr];
         rd_s <= s_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
